// File: rtl/bia_pkg.sv
`default_nettype none

package bia_pkg;

    localparam int MAP_DEPTH_DEF = 4096;

    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;
    localparam int LIM_W  = 17;

    localparam int ID_W     = 16;
    localparam int COUNT_W  = 13;
    localparam int CFG_W    = 16;
    localparam int CFG_AW   = 1;

    localparam logic [ID_W-1:0]    BASE_RST  = 16'd300;
    localparam logic [COUNT_W-1:0] COUNT_RST = 13'd4096;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_INIT    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_AGAIN = 2'd3
    } t_status;

    localparam logic [CFG_AW-1:0] CFG_BASE  = 1'd0;
    localparam logic [CFG_AW-1:0] CFG_COUNT = 1'd1;

endpackage

`default_nettype wire

// File: rtl/bitmap_id_allocator.sv
// Bitmap identifier allocator.
// Requests enter on i_operation / i_pid; a transaction is taken at a rising
// edge with start high and busy low. Each request yields exactly one result
// on o_status / o_allocated_id, marked by o_done for one cycle; the receiver
// cannot stall, and busy stays high until the result is out.
// The in-use bits live in one RAM of 64-bit rows, MAP_DEPTH/64 rows deep (rounded up).
// Allocate reads one row per cycle from row 0 and stops at the first row with
// a free bit or at the end of the usable ID range (id_count, capped by
// MAP_DEPTH and by the room above base_id). Release is a read-modify-write.
// Out-of-range, repeated initialize and unused codes answer from idle.
// The first initialize sweeps the RAM one row per cycle, clearing every row.
// After reset the same sweep runs with busy high; configuration writes
// through i_cfg_we are taken at any time and are meant to be issued while
// the block is idle.
// Register 0 is base_id, register 1 is id_count (low 13 bits of the data).
`default_nettype none

module bitmap_id_allocator #(
    parameter int MAP_DEPTH = bia_pkg::MAP_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   i_operation,
    input  wire logic [bia_pkg::ID_W-1:0]     i_pid,
    input  wire logic                         i_cfg_we,
    input  wire logic [bia_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [bia_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                              o_done,
    output logic [1:0]                        o_status,
    output logic [bia_pkg::ID_W-1:0]          o_allocated_id
);

    import bia_pkg::*;

    localparam int ROWS   = (MAP_DEPTH + WORD_W - 1) / WORD_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
    localparam logic [LIM_W-1:0]  DEPTH_L  = LIM_W'(MAP_DEPTH);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic                r_init, n_init;
    logic                r_clr_reply, n_clr_reply;
    logic [ID_W-1:0]     r_base;
    logic [COUNT_W-1:0]  r_count;
    logic                r_done, n_done;
    logic [1:0]          r_status, n_status;
    logic [ID_W-1:0]     r_alloc_id, n_alloc_id;

    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ROW_AW-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [LIM_W-1:0]    room;
    logic [LIM_W-1:0]    lim;
    logic [LIM_W-1:0]    row_start;
    logic [LIM_W-1:0]    next_start;
    logic [LIM_W-1:0]    remain;
    logic [WORD_W-1:0]   mask;
    logic [WORD_W-1:0]   free_bits;
    logic [WORD_W-1:0]   lowest;
    logic [BIT_W-1:0]    idx;
    logic [ID_W-1:0]     off;
    logic                in_range;
    logic [ROW_AW-1:0]   rel_row;

    bia_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS),
        .AW    (ROW_AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        room = LIM_W'(17'h10000) - {1'b0, r_base};
        lim  = LIM_W'(r_count);
        if (lim > DEPTH_L) begin
            lim = DEPTH_L;
        end
        if (lim > room) begin
            lim = room;
        end
    end

    always_comb begin
        row_start  = LIM_W'(r_row) << BIT_W;
        next_start = row_start + LIM_W'(WORD_W);
        remain     = lim - row_start;
        if (remain >= LIM_W'(WORD_W)) begin
            mask = '1;
        end else begin
            mask = (WORD_W'(1) << remain[BIT_W-1:0]) - WORD_W'(1);
        end
        free_bits = ~ram_rdata & mask;
        lowest    = free_bits & (~free_bits + WORD_W'(1));
        idx       = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (lowest[b]) begin
                idx = idx | BIT_W'(b);
            end
        end
    end

    always_comb begin
        off      = i_pid - r_base;
        in_range = (i_pid >= r_base) && ({1'b0, off} < lim);
        rel_row  = ROW_AW'(off >> BIT_W);
    end

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_bit       = r_bit;
        n_init      = r_init;
        n_clr_reply = r_clr_reply;
        n_done      = 1'b0;
        n_status    = r_status;
        n_alloc_id  = r_alloc_id;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = '0;
        ram_raddr   = r_row;

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_row == ROW_LAST) begin
                    n_state = S_IDLE;
                    if (r_clr_reply) begin
                        n_clr_reply = 1'b0;
                        n_done      = 1'b1;
                        n_status    = ST_OK;
                        n_alloc_id  = '0;
                    end
                end else begin
                    n_row = r_row + ROW_AW'(1);
                end
            end
            S_IDLE: begin
                ram_raddr = (i_operation == OP_RELEASE) ? rel_row : '0;
                if (start) begin
                    n_alloc_id = '0;
                    unique case (i_operation)
                        OP_ALLOC: begin
                            if (lim == '0) begin
                                n_done   = 1'b1;
                                n_status = ST_FULL;
                            end else begin
                                n_row   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        OP_RELEASE: begin
                            if (!in_range) begin
                                n_done   = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_row   = rel_row;
                                n_bit   = off[BIT_W-1:0];
                                n_state = S_REL;
                            end
                        end
                        OP_INIT: begin
                            if (r_init) begin
                                n_done   = 1'b1;
                                n_status = ST_AGAIN;
                            end else begin
                                n_init      = 1'b1;
                                n_clr_reply = 1'b1;
                                n_row       = '0;
                                n_state     = S_CLEAR;
                            end
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (free_bits != '0) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | lowest;
                    n_done     = 1'b1;
                    n_status   = ST_OK;
                    n_alloc_id = r_base + ID_W'(row_start) + ID_W'(idx);
                    n_state    = S_IDLE;
                end else if (next_start < lim) begin
                    ram_raddr = r_row + ROW_AW'(1);
                    n_row     = r_row + ROW_AW'(1);
                end else begin
                    n_done     = 1'b1;
                    n_status   = ST_FULL;
                    n_alloc_id = '0;
                    n_state    = S_IDLE;
                end
            end
            S_REL: begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(WORD_W'(1) << r_bit);
                n_done     = 1'b1;
                n_status   = ST_OK;
                n_alloc_id = '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_init      <= 1'b0;
            r_clr_reply <= 1'b0;
            r_done      <= 1'b0;
            r_base      <= BASE_RST;
            r_count     <= COUNT_RST;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_init      <= n_init;
            r_clr_reply <= n_clr_reply;
            r_done      <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_BASE:  r_base  <= i_cfg_wdata;
                    CFG_COUNT: r_count <= i_cfg_wdata[COUNT_W-1:0];
                    default:   r_base  <= r_base;
                endcase
            end
        end
        r_bit      <= n_bit;
        r_status   <= n_status;
        r_alloc_id <= n_alloc_id;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_allocated_id = r_alloc_id;

endmodule

`default_nettype wire

// File: rtl/bia_ram.sv
`default_nettype none

module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
